// ===== hdl/bps_pkg.sv =====
package bps_pkg;

   // Item kinds
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_SPAWN = 1'b1;

   // Register indexes on the csr port
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 12;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GRAVITY         = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_INTENSITY = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FADE_CAP        = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FAST_FADE_STEP  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_HEIGHT    = 3'd4;

   // Register reset values
   localparam logic [3:0]  GRAVITY_RESET         = 4'd4;
   localparam logic [7:0]  START_INTENSITY_RESET = 8'd120;
   localparam logic [4:0]  FADE_CAP_RESET        = 5'd31;
   localparam logic [4:0]  FAST_FADE_STEP_RESET  = 5'd6;
   localparam logic [11:0] START_HEIGHT_RESET    = 12'd256;

   // Spawn constants
   localparam logic signed [15:0] SPAWN_X_OFFSET = 16'sd8;
   localparam logic [15:0] VEL_X_BIAS = 16'd4;
   localparam logic [15:0] VEL_Y_BIAS = 16'd6;
   localparam logic [15:0] VEL_H_BIAS = 16'd56;

   // Draw constants
   localparam logic signed [17:0] SPRITE_Y_OFFSET = 18'sd8;
   localparam logic signed [12:0] DEPTH_BASE      = 13'sd256;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] source_x;
      logic signed [15:0] source_y;
      logic signed [15:0] camera_x;
      logic signed [15:0] camera_y;
      logic [4:0]         rand_vx;
      logic [3:0]         rand_vy;
      logic [5:0]         rand_vh;
      logic [1:0]         rand_look;
      logic               fast_forward;
   } req_type;

   typedef struct packed {
      logic               visible;
      logic [1:0]         look_index;
      logic [4:0]         anim_level;
      logic [4:0]         shadow_level;
      logic signed [11:0] shadow_x;
      logic signed [11:0] shadow_y;
      logic signed [11:0] shadow_height;
      logic signed [19:0] sprite_x;
      logic signed [21:0] sprite_y;
      logic signed [16:0] sprite_depth;
   } rsp_type;

endpackage

// ===== hdl/bouncing_particle_step_core.sv =====
// One Q4 fixed-point bouncing particle. Each accepted beat (spawn or tick)
// produces exactly one response beat, and a new beat can be taken every cycle
// that req_stall is low: the particle state and the response register are
// both updated at the accepting edge by one pass of short add/compare logic.
// req_stall is high only while a response is held by rsp_stall. Spawn and
// inactive ticks return an all-zero, not-visible response. The csr port is
// always ready and should only be written while the block is idle.
module bouncing_particle_step_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  bps_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output bps_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bps_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [bps_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   // Signed divide by 16, truncating toward zero
   function automatic logic signed [11:0] div16(input logic signed [15:0] v);
      logic signed [15:0] t;
      t = v + (v[15] ? 16'sd15 : 16'sd0);
      return t[15:4];
   endfunction

   // Signed halve, truncating toward zero
   function automatic logic signed [15:0] half(input logic signed [15:0] v);
      logic signed [15:0] t;
      t = v + {15'b0, v[15]};
      return t >>> 1;
   endfunction

   // Configuration registers
   logic [3:0]  gravity_ff;
   logic [7:0]  start_intensity_ff;
   logic [4:0]  fade_cap_ff;
   logic [4:0]  fast_fade_step_ff;
   logic [11:0] start_height_ff;

   // Particle state
   logic signed [15:0] pos_x_ff, pos_x_in;
   logic signed [15:0] pos_y_ff, pos_y_in;
   logic signed [15:0] pos_h_ff, pos_h_in;
   logic signed [15:0] vel_x_ff, vel_x_in;
   logic signed [15:0] vel_y_ff, vel_y_in;
   logic signed [15:0] vel_h_ff, vel_h_in;
   logic [7:0]         level_ff, level_in;
   logic               live_ff, live_in;
   logic [1:0]         look_ff, look_in;

   // Response register
   logic             rsp_valid_ff, rsp_valid_in;
   bps_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic req_accept;

   // Working values for a tick
   logic signed [15:0] dx, dy;
   logic [7:0]         capped;
   logic [4:0]         anim;
   logic [7:0]         anim7;
   logic signed [15:0] px, py, ph, vh;
   logic signed [11:0] yq;
   logic signed [17:0] sy_sum;
   logic signed [12:0] depth;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff         <= bps_pkg::GRAVITY_RESET;
         start_intensity_ff <= bps_pkg::START_INTENSITY_RESET;
         fade_cap_ff        <= bps_pkg::FADE_CAP_RESET;
         fast_fade_step_ff  <= bps_pkg::FAST_FADE_STEP_RESET;
         start_height_ff    <= bps_pkg::START_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bps_pkg::CSR_GRAVITY:         gravity_ff         <= csr_data[3:0];
            bps_pkg::CSR_START_INTENSITY: start_intensity_ff <= csr_data[7:0];
            bps_pkg::CSR_FADE_CAP:        fade_cap_ff        <= csr_data[4:0];
            bps_pkg::CSR_FAST_FADE_STEP:  fast_fade_step_ff  <= csr_data[4:0];
            bps_pkg::CSR_START_HEIGHT:    start_height_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Next state and response
   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_h_in = pos_h_ff;
      vel_x_in = vel_x_ff;
      vel_y_in = vel_y_ff;
      vel_h_in = vel_h_ff;
      level_in = level_ff;
      live_in  = live_ff;
      look_in  = look_ff;
      rsp_data_in = '0;

      // spawn placement
      dx = req_data.source_x - req_data.camera_x + bps_pkg::SPAWN_X_OFFSET;
      dy = req_data.source_y - req_data.camera_y;

      // fade
      capped = (level_ff > {3'b0, fade_cap_ff}) ? {3'b0, fade_cap_ff} : level_ff;
      anim   = capped[4:0];
      anim7  = {3'b0, anim} * 8'd7;

      // motion, then bounce
      px = pos_x_ff + vel_x_ff;
      py = pos_y_ff + vel_y_ff;
      ph = pos_h_ff + vel_h_ff;
      vh = vel_h_ff - $signed({12'b0, gravity_ff});

      // draw values
      yq     = div16(py);
      if (ph[15] || ph == '0) begin
         sy_sum = 18'(py) - 18'(16'(-ph)) + bps_pkg::SPRITE_Y_OFFSET;
      end else begin
         sy_sum = 18'(py) - 18'(ph) + bps_pkg::SPRITE_Y_OFFSET;
      end
      depth = bps_pkg::DEPTH_BASE - 13'(yq);

      if (req_data.kind == bps_pkg::KIND_SPAWN) begin
         pos_x_in = {dx[11:0], 4'b0};
         pos_y_in = {dy[11:0], 4'b0};
         pos_h_in = {4'b0, start_height_ff};
         vel_x_in = {11'b0, req_data.rand_vx} + bps_pkg::VEL_X_BIAS;
         vel_y_in = {12'b0, req_data.rand_vy} - bps_pkg::VEL_Y_BIAS;
         vel_h_in = {10'b0, req_data.rand_vh} + bps_pkg::VEL_H_BIAS;
         level_in = start_intensity_ff;
         look_in  = req_data.rand_look;
         live_in  = 1'b1;
      end else if (live_ff) begin
         if (level_ff == '0) begin
            live_in = 1'b0;
         end else begin
            if (req_data.fast_forward) begin
               level_in = (capped < {3'b0, fast_fade_step_ff}) ? '0 :
                          capped - {3'b0, fast_fade_step_ff};
            end else begin
               level_in = level_ff - 8'd1;
            end
            pos_x_in = px;
            pos_y_in = py;
            pos_h_in = ph;
            vel_h_in = vh;
            if (ph[15] || ph == '0) begin
               pos_h_in = -ph;
               vel_x_in = half(vel_x_ff);
               vel_y_in = half(vel_y_ff);
               vel_h_in = -half(vh);
            end
            rsp_data_in.visible       = 1'b1;
            rsp_data_in.look_index    = look_ff;
            rsp_data_in.anim_level    = anim;
            rsp_data_in.shadow_level  = anim7[7:3];
            rsp_data_in.shadow_x      = div16(px);
            rsp_data_in.shadow_y      = yq;
            rsp_data_in.shadow_height = div16(pos_h_in);
            rsp_data_in.sprite_x      = {px, 4'b0};
            rsp_data_in.sprite_y      = {sy_sum, 4'b0};
            rsp_data_in.sprite_depth  = {depth, 4'b0};
         end
      end
   end

   // Response valid: loads on accept, clears when taken
   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         live_ff      <= 1'b0;
         level_ff     <= '0;
         look_ff      <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         pos_h_ff     <= '0;
         vel_x_ff     <= '0;
         vel_y_ff     <= '0;
         vel_h_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            live_ff  <= live_in;
            level_ff <= level_in;
            look_ff  <= look_in;
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
            pos_h_ff <= pos_h_in;
            vel_x_ff <= vel_x_in;
            vel_y_ff <= vel_y_in;
            vel_h_ff <= vel_h_in;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
